// ===== design/udlt_pkg.sv =====
// ----------------------------------------------------------------------------
// udlt_pkg
// Shared types and constants for the UTF-8 decoder with line tracking.
// ----------------------------------------------------------------------------
`default_nettype none

package udlt_pkg;

	// Counter widths; each counter saturates at all ones of its own width.
	localparam int LINE_BITS   = 24;
	localparam int COLUMN_BITS = 16;
	localparam int OFFSET_BITS = 31;

	// Result field widths.
	localparam int CP_W     = 21;
	localparam int LINE_W   = 24;
	localparam int COLUMN_W = 16;
	localparam int OFFSET_W = 31;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Lead and continuation byte patterns.
	localparam logic [7:0] LEAD4_MASK    = 8'hf8;
	localparam logic [7:0] LEAD4_TAG     = 8'hf0;
	localparam logic [7:0] LEAD4_PAYLOAD = 8'h07;
	localparam logic [7:0] LEAD3_MASK    = 8'hf0;
	localparam logic [7:0] LEAD3_TAG     = 8'he0;
	localparam logic [7:0] LEAD3_PAYLOAD = 8'h0f;
	localparam logic [7:0] LEAD2_MASK    = 8'he0;
	localparam logic [7:0] LEAD2_TAG     = 8'hc0;
	localparam logic [7:0] LEAD2_PAYLOAD = 8'h1f;
	localparam logic [7:0] CONT_MASK     = 8'hc0;
	localparam logic [7:0] CONT_TAG      = 8'h80;
	localparam logic [7:0] CONT_PAYLOAD  = 8'h3f;
	localparam logic [7:0] ASCII_MASK    = 8'h80;

	localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00fffd;
	localparam logic [CP_W-1:0] CP_LF          = 21'h00000a;
	localparam logic [CP_W-1:0] CP_CR          = 21'h00000d;

	// Continuation bytes still expected.
	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_ONE   = 2'd1;
	localparam logic [1:0] PEND_TWO   = 2'd2;
	localparam logic [1:0] PEND_THREE = 2'd3;

	// One decoded character on its way from front to back.
	typedef struct packed {
		logic [CP_W-1:0]        cp;
		logic                   newline;
		logic [OFFSET_BITS-1:0] offset;
		logic                   last;
	} char_t;

endpackage

`default_nettype wire

// ===== design/utf8_decode_line_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_decode_line_tracker_unit
// UTF-8 decoder with CR/LF folding and saturating line, column, offset tracking.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           payload
//   source    in         push / full         data_byte, end_of_input
//   result    out        empty / pop         code_point, line_number, column,
//                                            byte_offset, last
//
// One byte is taken per cycle while full is low; a byte that yields two results (an error that
// closes an open sequence plus its own character) holds full until the front has pushed
// the second beat into the four-entry character queue.
// A result reaches the result ports through the character queue and then the result register.
// full also rises when the character queue fills behind a stalled result port.
// arst_n clears the decoder state, the counters, the held second beat and the queue; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_decode_line_tracker_unit (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic [7:0]               data_byte,
	input  wire logic                     end_of_input,
	output logic                          empty,
	input  wire logic                     pop,
	output logic [udlt_pkg::CP_W-1:0]     code_point,
	output logic [udlt_pkg::LINE_W-1:0]   line_number,
	output logic [udlt_pkg::COLUMN_W-1:0] column,
	output logic [udlt_pkg::OFFSET_W-1:0] byte_offset,
	output logic                          last
);

	logic            q_full, q_push, q_valid, q_pop;
	udlt_pkg::char_t q_wdata, q_rdata;

	udlt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.end_of_input (end_of_input),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	udlt_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.valid   (q_valid)
	);

	udlt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_rdata),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.code_point  (code_point),
		.line_number (line_number),
		.column      (column),
		.byte_offset (byte_offset),
		.last        (last)
	);

endmodule

`default_nettype wire

// ===== design/udlt_front.sv =====
// ----------------------------------------------------------------------------
// udlt_front
// Accepts source bytes, decodes UTF-8, folds CR/LF and tracks byte offset.
// ----------------------------------------------------------------------------
`default_nettype none

module udlt_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [7:0]            data_byte,
	input  wire logic                  end_of_input,
	input  wire logic                  q_full,
	output logic                       q_push,
	output udlt_pkg::char_t            q_data
);

	logic [1:0]                      pend_q, pend_n;
	logic [udlt_pkg::CP_W-1:0]       part_q, part_n, part_shift;
	logic                            cr_q, cr_n, cr_mid, cr_end;
	logic [udlt_pkg::OFFSET_BITS-1:0] off_q, off_n, off_inc;
	logic                            hold_valid_q;
	udlt_pkg::char_t                 hold_q;

	logic                            accept;
	logic                            is_cont;
	logic                            c0_v, c1_v;
	logic [udlt_pkg::CP_W-1:0]       c0_cp, c1_cp;
	logic [udlt_pkg::OFFSET_BITS-1:0] c0_off, c1_off;
	logic                            keep0, keep1;
	logic                            nl0, nl1;
	udlt_pkg::char_t                 e0, e1, first, second;
	logic                            first_v, second_v;

	assign full   = hold_valid_q || q_full;
	assign accept = push && !full;

	assign off_inc    = (off_q == '1) ? off_q : off_q + 1'b1;
	assign is_cont    = (data_byte & udlt_pkg::CONT_MASK) == udlt_pkg::CONT_TAG;
	assign part_shift = {part_q[udlt_pkg::CP_W-7:0], data_byte[5:0]};

	// Decode: c0 is an error that closes an open sequence, c1 the byte's own character.
	always_comb begin
		c0_v   = 1'b0;
		c0_cp  = udlt_pkg::CP_REPLACEMENT;
		c0_off = off_q;
		c1_v   = 1'b0;
		c1_cp  = udlt_pkg::CP_REPLACEMENT;
		c1_off = off_inc;
		pend_n = pend_q;
		part_n = part_q;
		off_n  = off_q;
		if (end_of_input) begin
			c1_v   = (pend_q != udlt_pkg::PEND_NONE);
			c1_off = off_q;
			pend_n = udlt_pkg::PEND_NONE;
			part_n = '0;
		end else if (pend_q != udlt_pkg::PEND_NONE && is_cont) begin
			off_n  = off_inc;
			pend_n = pend_q - 1'b1;
			if (pend_q == udlt_pkg::PEND_ONE) begin
				c1_v   = 1'b1;
				c1_cp  = part_shift;
				part_n = '0;
			end else begin
				part_n = part_shift;
			end
		end else begin
			c0_v   = (pend_q != udlt_pkg::PEND_NONE);
			off_n  = off_inc;
			pend_n = udlt_pkg::PEND_NONE;
			part_n = '0;
			if ((data_byte & udlt_pkg::LEAD4_MASK) == udlt_pkg::LEAD4_TAG) begin
				pend_n = udlt_pkg::PEND_THREE;
				part_n = udlt_pkg::CP_W'(data_byte & udlt_pkg::LEAD4_PAYLOAD);
			end else if ((data_byte & udlt_pkg::LEAD3_MASK) == udlt_pkg::LEAD3_TAG) begin
				pend_n = udlt_pkg::PEND_TWO;
				part_n = udlt_pkg::CP_W'(data_byte & udlt_pkg::LEAD3_PAYLOAD);
			end else if ((data_byte & udlt_pkg::LEAD2_MASK) == udlt_pkg::LEAD2_TAG) begin
				pend_n = udlt_pkg::PEND_ONE;
				part_n = udlt_pkg::CP_W'(data_byte & udlt_pkg::LEAD2_PAYLOAD);
			end else if ((data_byte & udlt_pkg::ASCII_MASK) == 8'h00) begin
				c1_v  = 1'b1;
				c1_cp = udlt_pkg::CP_W'(data_byte);
			end else begin
				c1_v = 1'b1;
			end
		end
	end

	// Newline folding: drop an LF right after a CR, mark CR and LF as newline.
	always_comb begin
		nl0    = (c0_cp == udlt_pkg::CP_LF) || (c0_cp == udlt_pkg::CP_CR);
		keep0  = c0_v && !((c0_cp == udlt_pkg::CP_LF) && cr_q);
		cr_mid = c0_v ? (c0_cp == udlt_pkg::CP_CR) : cr_q;
		nl1    = (c1_cp == udlt_pkg::CP_LF) || (c1_cp == udlt_pkg::CP_CR);
		keep1  = c1_v && !((c1_cp == udlt_pkg::CP_LF) && cr_mid);
		cr_end = c1_v ? (c1_cp == udlt_pkg::CP_CR) : cr_mid;
		cr_n   = end_of_input ? 1'b0 : cr_end;

		e0.cp      = nl0 ? udlt_pkg::CP_LF : c0_cp;
		e0.newline = nl0;
		e0.offset  = c0_off;
		e0.last    = 1'b0;
		e1.cp      = nl1 ? udlt_pkg::CP_LF : c1_cp;
		e1.newline = nl1;
		e1.offset  = c1_off;
		e1.last    = 1'b1;

		first_v    = keep0 || keep1;
		second_v   = keep0 && keep1;
		first      = keep0 ? e0 : e1;
		first.last = !second_v;
		second     = e1;
	end

	// A byte with two results holds its second beat and pushes it once the queue has room.
	always_comb begin
		q_push = (hold_valid_q && !q_full) || (accept && first_v);
		q_data = hold_valid_q ? hold_q : first;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= udlt_pkg::PEND_NONE;
			part_q       <= '0;
			cr_q         <= 1'b0;
			off_q        <= '0;
			hold_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pend_q <= pend_n;
				part_q <= part_n;
				cr_q   <= cr_n;
				off_q  <= off_n;
			end
			if (accept && second_v) begin
				hold_valid_q <= 1'b1;
			end else if (hold_valid_q && !q_full) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && second_v) begin
			hold_q <= second;
		end
	end

	a_hold_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> !accept)
		else $error("byte accepted while a second beat is held");

	a_hold_from_split: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hold_valid_q) |-> $past(accept))
		else $error("second beat held without an accepted byte");

endmodule

`default_nettype wire

// ===== design/udlt_fifo.sv =====
// ----------------------------------------------------------------------------
// udlt_fifo
// Short character queue between the decoder front and the counting back.
// ----------------------------------------------------------------------------
`default_nettype none

module udlt_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire udlt_pkg::char_t wr_data,
	output logic                 full,
	input  wire logic            rd_en,
	output udlt_pkg::char_t      rd_data,
	output logic                 valid
);

	udlt_pkg::char_t                  mem_q [udlt_pkg::QUEUE_DEPTH];
	logic [udlt_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [udlt_pkg::QUEUE_CNT_W-1:0] count_q;

	assign full    = (count_q == udlt_pkg::QUEUE_CNT_W'(udlt_pkg::QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == udlt_pkg::QUEUE_PTR_W'(udlt_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == udlt_pkg::QUEUE_PTR_W'(udlt_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && full))
		else $error("write into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && !valid))
		else $error("read from an empty queue");

endmodule

`default_nettype wire

// ===== design/udlt_back.sv =====
// ----------------------------------------------------------------------------
// udlt_back
// Takes decoded characters, advances line and column, holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module udlt_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire udlt_pkg::char_t               q_data,
	output logic                               q_pop,
	output logic                               empty,
	input  wire logic                          pop,
	output logic [udlt_pkg::CP_W-1:0]          code_point,
	output logic [udlt_pkg::LINE_W-1:0]        line_number,
	output logic [udlt_pkg::COLUMN_W-1:0]      column,
	output logic [udlt_pkg::OFFSET_W-1:0]      byte_offset,
	output logic                               last
);

	logic                              out_valid_q;
	logic [udlt_pkg::LINE_BITS-1:0]    line_q;
	logic [udlt_pkg::COLUMN_BITS-1:0]  col_q;
	logic [udlt_pkg::CP_W-1:0]         cp_q;
	logic [udlt_pkg::OFFSET_BITS-1:0]  off_q;
	logic                              last_q;

	// Load the result slot when it is free or being popped this cycle.
	assign q_pop = q_valid && (!out_valid_q || pop);
	assign empty = !out_valid_q;

	// Counters only move on a load, so they double as the result fields.
	assign code_point  = cp_q;
	assign line_number = udlt_pkg::LINE_W'(line_q);
	assign column      = udlt_pkg::COLUMN_W'(col_q);
	assign byte_offset = udlt_pkg::OFFSET_W'(off_q);
	assign last        = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			line_q      <= '0;
			col_q       <= '0;
		end else begin
			if (q_pop) begin
				out_valid_q <= 1'b1;
				if (q_data.newline) begin
					line_q <= (line_q == '1) ? line_q : line_q + 1'b1;
					col_q  <= '0;
				end else begin
					col_q <= (col_q == '1) ? col_q : col_q + 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cp_q   <= q_data.cp;
			off_q  <= q_data.offset;
			last_q <= q_data.last;
		end
	end

	a_newline_resets_column: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (cp_q == udlt_pkg::CP_LF) |-> (col_q == '0))
		else $error("newline result with nonzero column");

endmodule

`default_nettype wire
